// ===== sv/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants
// Operation and status codes, payload widths and the per-cell command bundle
// for the stack with remove-by-value.
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;
    localparam int MOVE_W    = 16;

    localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef logic [VALUE_W-1:0] value_t;

    // command broadcast to every cell in the chain
    typedef struct packed {
        logic push_en;    // a push is accepted and the stack is not full
        logic remove_en;  // a remove is accepted and some cell matched
    } cell_cmd_t;

endpackage

// ===== sv/swr_cell.sv =====
// ----------------------------------------------------------------------------
// swr_cell: one stack entry
// Holds one value, compares it with the operand, passes the match chain
// downward and takes its upper neighbor's value when a removal closes a gap.
// ----------------------------------------------------------------------------
module swr_cell #(
    parameter int CNT_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                aclk,
    input  swr_pkg::cell_cmd_t  cmd,
    input  logic [CNT_W-1:0]    count,
    input  swr_pkg::value_t     operand,
    input  swr_pkg::value_t     upper_entry,
    input  logic                match_above_in,
    output logic                match_above_out,
    output logic                topmost,
    output swr_pkg::value_t     entry
);

    swr_pkg::value_t entry_reg;
    swr_pkg::value_t entry_next;
    logic            occupied;
    logic            my_match;

    assign occupied        = CNT_W'(CELL_IDX) < count;
    assign my_match        = occupied && (entry_reg == operand);
    assign match_above_out = match_above_in | my_match;
    assign topmost         = my_match & ~match_above_in;
    assign entry           = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.push_en && (count == CNT_W'(CELL_IDX))) begin
            entry_next = operand;
        end else if (cmd.remove_en && !match_above_in) begin
            // at or above the topmost match: slide down one place
            entry_next = upper_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== sv/stack_with_remove_by_value.sv =====
// ----------------------------------------------------------------------------
// stack_with_remove_by_value: bounded LIFO with remove-by-value
// Usage: items enter on s_valid/s_ready carrying s_op (push, pop, remove)
// and s_operand_value. Every item gives exactly one result on
// m_valid/m_ready: m_popped_value, m_status, m_fill_count, m_move_total.
// The result is registered at the edge that takes the item. Throughput is
// one item per cycle while results are taken; entries sit in a row of cells
// that all compare against the operand at once, and a remove shifts the
// cells at and above the topmost match down by one in the same cycle.
// Codes opcode 3 as no operation. Push on full, pop on empty and remove
// without a match report their status and leave the entries untouched.
// Reset (synchronous, aresetn low) empties the stack and clears the move
// count and the output valid flag; entry contents and result fields are not cleared.
// When the receiver stalls, the result holds and s_ready drops until it is
// taken; s_ready is high whenever the output register is empty or drains.
// ----------------------------------------------------------------------------
module stack_with_remove_by_value #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [swr_pkg::OP_W-1:0]      s_op,
    input  logic signed [swr_pkg::VALUE_W-1:0] s_operand_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [swr_pkg::VALUE_W-1:0] m_popped_value,
    output logic [swr_pkg::STATUS_W-1:0]  m_status,
    output logic [swr_pkg::FILL_W-1:0]    m_fill_count,
    output logic [swr_pkg::MOVE_W-1:0]    m_move_total
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int ADD_W = CNT_W + 1;
    localparam int SUM_W = swr_pkg::MOVE_W + 1;

    logic [CNT_W-1:0]           count_reg, count_next;
    logic [swr_pkg::MOVE_W-1:0] move_reg, move_next;

    logic                         m_valid_reg;
    swr_pkg::value_t              m_popped_reg, m_popped_next;
    logic [swr_pkg::STATUS_W-1:0] m_status_reg, m_status_next;

    swr_pkg::value_t    entry_q [STACK_DEPTH];
    swr_pkg::value_t    upper_q [STACK_DEPTH];
    logic [STACK_DEPTH:0] match_chain;
    logic [STACK_DEPTH-1:0] topmost;

    swr_pkg::cell_cmd_t cmd;
    logic               accept;
    logic               full;
    logic               empty;
    logic               found;
    logic [IDX_W-1:0]   hit_idx;
    logic [CNT_W-1:0]   top_pos;
    logic [CNT_W-1:0]   above;
    logic [ADD_W-1:0]   move_add;
    logic [SUM_W-1:0]   move_sum;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign full    = count_reg == CNT_W'(STACK_DEPTH);
    assign empty   = count_reg == '0;
    assign found   = match_chain[0];
    assign top_pos = count_reg - CNT_W'(1);

    assign cmd.push_en   = accept && (s_op == swr_pkg::OP_PUSH) && !full;
    assign cmd.remove_en = accept && (s_op == swr_pkg::OP_REMOVE) && found;

    assign match_chain[STACK_DEPTH] = 1'b0;

    genvar j;
    generate
        for (j = 0; j < STACK_DEPTH; j++) begin : g_cell
            if (j == STACK_DEPTH - 1) begin : g_top
                assign upper_q[j] = entry_q[j];
            end else begin : g_mid
                assign upper_q[j] = entry_q[j+1];
            end

            swr_cell #(
                .CNT_W    (CNT_W),
                .CELL_IDX (j)
            ) u_cell (
                .aclk            (aclk),
                .cmd             (cmd),
                .count           (count_reg),
                .operand         (s_operand_value),
                .upper_entry     (upper_q[j]),
                .match_above_in  (match_chain[j+1]),
                .match_above_out (match_chain[j]),
                .topmost         (topmost[j]),
                .entry           (entry_q[j])
            );
        end
    endgenerate

    // index of the topmost match, at most one cell flags it
    always_comb begin
        hit_idx = '0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            if (topmost[k]) begin
                hit_idx = hit_idx | IDX_W'(k);
            end
        end
    end

    assign above    = top_pos - CNT_W'(hit_idx);
    assign move_add = found ? {above, 1'b1} : {count_reg, 1'b1};
    assign move_sum = {1'b0, move_reg} + SUM_W'(move_add);

    always_comb begin
        count_next    = count_reg;
        move_next     = move_reg;
        m_popped_next = '0;
        m_status_next = swr_pkg::ST_OK;
        case (s_op)
            swr_pkg::OP_PUSH: begin
                if (full) begin
                    m_status_next = swr_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            swr_pkg::OP_POP: begin
                if (empty) begin
                    m_status_next = swr_pkg::ST_EMPTY;
                end else begin
                    count_next    = top_pos;
                    m_popped_next = entry_q[top_pos[IDX_W-1:0]];
                end
            end
            swr_pkg::OP_REMOVE: begin
                move_next = move_sum[SUM_W-1] ? swr_pkg::MOVE_MAX
                                              : move_sum[swr_pkg::MOVE_W-1:0];
                if (found) begin
                    count_next = top_pos;
                end else begin
                    m_status_next = swr_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            move_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                move_reg    <= move_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_popped_reg <= m_popped_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_reg;
    assign m_status       = m_status_reg;
    assign m_fill_count   = swr_pkg::FILL_W'(count_reg);
    assign m_move_total   = move_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count beyond depth");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(topmost))
        else $error("more than one topmost match");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove_en |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove hit did not shrink the stack");

    a_full_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == swr_pkg::OP_PUSH) && full) |=>
            count_reg == $past(count_reg))
        else $error("push on full changed the count");

    a_moves_monotonic: assert property (@(posedge aclk)
        (aresetn && $past(aresetn)) |-> move_reg >= $past(move_reg))
        else $error("move count went down");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for stack_with_remove_by_value
// Drives push, pop and remove-by-value items through the valid/ready input,
// keeps a shadow copy of the stack to work out each result, and compares
// every result item field by field. Covers the corner operations, a full
// stack, random traffic under several idle/stall mixes and misses on a full
// stack.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH = 16;
    localparam logic [swr_pkg::OP_W-1:0] OP_NOP = 2'd3;

    typedef struct {
        swr_pkg::value_t                popped;
        logic [swr_pkg::STATUS_W-1:0]   status;
        logic [swr_pkg::FILL_W-1:0]     fill;
        logic [swr_pkg::MOVE_W-1:0]     moves;
    } stack_result_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [swr_pkg::OP_W-1:0]            s_op = swr_pkg::OP_PUSH;
    logic signed [swr_pkg::VALUE_W-1:0]  s_operand_value = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [swr_pkg::VALUE_W-1:0]  m_popped_value;
    logic [swr_pkg::STATUS_W-1:0]        m_status;
    logic [swr_pkg::FILL_W-1:0]          m_fill_count;
    logic [swr_pkg::MOVE_W-1:0]          m_move_total;

    // shadow copy of the stack
    swr_pkg::value_t shadow_entries [DEPTH];
    int              shadow_count = 0;
    int              shadow_moves = 0;

    stack_result_t pending_results [$];
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    swr_pkg::value_t value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                        32'h8000_0000, 32'h7fff_ffff, 32'h0000_002a,
                                        32'h5555_aaaa, 32'haaaa_5555};

    stack_with_remove_by_value #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_operand_value (s_operand_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_popped_value  (m_popped_value),
        .m_status        (m_status),
        .m_fill_count    (m_fill_count),
        .m_move_total    (m_move_total)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic stack_result_t stack_apply(input logic [swr_pkg::OP_W-1:0] op,
                                                  input swr_pkg::value_t val);
        stack_result_t r;
        int hit;
        int moves;
        r.popped = '0;
        r.status = swr_pkg::ST_OK;
        hit = -1;
        moves = 0;
        case (op)
            swr_pkg::OP_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    r.status = swr_pkg::ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = val;
                    shadow_count++;
                end
            end
            swr_pkg::OP_POP: begin
                if (shadow_count == 0) begin
                    r.status = swr_pkg::ST_EMPTY;
                end else begin
                    shadow_count--;
                    r.popped = shadow_entries[shadow_count];
                end
            end
            swr_pkg::OP_REMOVE: begin
                // topmost match wins
                for (int i = shadow_count - 1; i >= 0 && hit < 0; i--) begin
                    if (shadow_entries[i] == val) hit = i;
                end
                if (hit >= 0) begin
                    moves = 2 * (shadow_count - 1 - hit) + 1;
                    for (int j = hit; j < shadow_count - 1; j++) begin
                        shadow_entries[j] = shadow_entries[j + 1];
                    end
                    shadow_count--;
                end else begin
                    moves = 2 * shadow_count + 1;
                    r.status = swr_pkg::ST_NOT_FOUND;
                end
                shadow_moves = (shadow_moves + moves > int'(swr_pkg::MOVE_MAX)) ?
                               int'(swr_pkg::MOVE_MAX) : shadow_moves + moves;
            end
            default: begin
            end
        endcase
        r.fill = shadow_count[swr_pkg::FILL_W-1:0];
        r.moves = shadow_moves[swr_pkg::MOVE_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch on %s: expected %0h actual %0h", $time, what, want, got);
            error_count++;
        end
    endfunction

    // result check first, then the item taken at this edge
    always @(posedge aclk) begin
        stack_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result item: expected none actual %0h %0h %0h %0h",
                             $time, m_popped_value, m_status, m_fill_count, m_move_total);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("popped_value", want.popped, m_popped_value);
                    check_field("status", 32'(want.status), 32'(m_status));
                    check_field("fill_count", 32'(want.fill), 32'(m_fill_count));
                    check_field("move_total", 32'(want.moves), 32'(m_move_total));
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(stack_apply(s_op, s_operand_value));
            end
        end
    end

    task automatic send_item(input logic [swr_pkg::OP_W-1:0] op, input swr_pkg::value_t val);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            s_op <= 2'($urandom());
            s_operand_value <= $urandom();
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_operand_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic swr_pkg::value_t pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return value_pool[$urandom_range(7)];
        if (sel < 7 || shadow_count == 0) return $urandom();
        if (sel < 9) return shadow_entries[$urandom_range(shadow_count - 1)];
        return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    task automatic test_corner_ops();
        idle_pct = 0;
        stall_pct = 0;
        send_item(swr_pkg::OP_POP, 32'h1234_5678);          // pop when empty
        send_item(swr_pkg::OP_REMOVE, 32'h0000_0007);       // remove on empty stack
        send_item(OP_NOP, 32'hdead_beef);
        send_item(swr_pkg::OP_PUSH, 32'h8000_0000);
        send_item(swr_pkg::OP_PUSH, 32'h7fff_ffff);
        send_item(swr_pkg::OP_PUSH, 32'h0000_0000);
        send_item(swr_pkg::OP_PUSH, 32'hffff_ffff);
        send_item(swr_pkg::OP_PUSH, 32'h8000_0000);
        send_item(swr_pkg::OP_REMOVE, 32'h8000_0000);       // duplicate: top copy goes
        send_item(swr_pkg::OP_REMOVE, 32'h7fff_ffff);       // match with entries above
        send_item(swr_pkg::OP_REMOVE, 32'h0001_2345);       // no match
        send_item(OP_NOP, 32'hffff_ffff);
        send_item(swr_pkg::OP_POP, 32'h0000_0000);
        send_item(swr_pkg::OP_POP, 32'hffff_ffff);
        send_item(swr_pkg::OP_POP, 32'h5555_5555);
        send_item(swr_pkg::OP_POP, 32'haaaa_aaaa);
        wait_drained();
    endtask

    task automatic test_full_stack();
        swr_pkg::value_t bottom;
        idle_pct = 0;
        stall_pct = 0;
        bottom = 32'h0bad_cafe;
        send_item(swr_pkg::OP_PUSH, bottom);
        repeat (DEPTH) send_item(swr_pkg::OP_PUSH, $urandom());
        send_item(swr_pkg::OP_PUSH, 32'h7fff_ffff);         // push when full
        send_item(swr_pkg::OP_REMOVE, bottom);              // deepest match, all entries shift
        send_item(swr_pkg::OP_PUSH, 32'h8000_0000);
        repeat (DEPTH + 1) send_item(swr_pkg::OP_POP, $urandom());
        wait_drained();
    endtask

    task automatic test_random(input int idle, input int stall, input int count);
        int push_weight;
        int pick;
        logic [swr_pkg::OP_W-1:0] op;
        idle_pct = idle;
        stall_pct = stall;
        push_weight = 40;
        for (int n = 0; n < count; n++) begin
            // switch at random between filling and draining stretches
            if (n % 60 == 0) push_weight = $urandom_range(1) ? 60 : 25;
            pick = $urandom_range(99);
            if (pick < push_weight) op = swr_pkg::OP_PUSH;
            else if (pick < push_weight + (95 - push_weight) / 2) op = swr_pkg::OP_POP;
            else if (pick < 95) op = swr_pkg::OP_REMOVE;
            else op = OP_NOP;
            send_item(op, pick_value());
        end
        wait_drained();
    endtask

    task automatic test_full_misses();
        idle_pct = 10;
        stall_pct = 10;
        repeat (DEPTH + 4) send_item(swr_pkg::OP_POP, $urandom());
        for (int i = 0; i < DEPTH; i++) send_item(swr_pkg::OP_PUSH, {16'h1111, 16'(i)});
        // misses on a full stack add the most per item
        repeat (30) send_item(swr_pkg::OP_REMOVE, {16'h2222, 16'($urandom())});
        send_item(swr_pkg::OP_REMOVE, {16'h1111, 16'd3});
        send_item(swr_pkg::OP_PUSH, 32'h8000_0000);
        send_item(OP_NOP, 32'h0000_0000);
        send_item(swr_pkg::OP_POP, 32'h0000_0000);
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_ops();
        test_full_stack();
        test_random(0, 0, 250);
        test_random(79, 0, 250);
        test_random(0, 79, 250);
        test_random(36, 36, 250);
        test_full_misses();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("stack_with_remove_by_value verification clean");
        end else begin
            $display("stack_with_remove_by_value verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("stack_with_remove_by_value verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/swr_pkg.sv
sv/swr_cell.sv
sv/stack_with_remove_by_value.sv
dv/tb.sv
